// ===== design/tcw_pkg.sv =====
// Shared constants and types for the text console character writer.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int MODE_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int COLOUT_W = 7;
  localparam int ROWOUT_W = 5;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  // Side effects of one put-character step.
  typedef struct packed {
    logic cell_wr;
    logic scroll;
  } put_flags_t;

endpackage

// ===== design/tcw_if.sv =====
// Handshake channel interfaces: input items, results and attribute writes.
`timescale 1ns / 1ps

interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::MODE_W-1:0]   mode;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::INDEX_W-1:0]  cell_index;
  modport source (output valid, mode, char_code, cell_index, input ready);
  modport sink   (input valid, mode, char_code, cell_index, output ready);
endinterface

interface tcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::COLOUT_W-1:0]  column_now;
  logic [tcw_pkg::ROWOUT_W-1:0]  row_now;
  logic [tcw_pkg::CELL_W-1:0]    read_data;
  logic                          scrolled;
  modport source (output valid, column_now, row_now, read_data, scrolled, input ready);
  modport sink   (input valid, column_now, row_now, read_data, scrolled, output ready);
endinterface

interface tcw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::ATTR_W-1:0]  text_attribute;
  modport source (output valid, text_attribute, input ready);
  modport sink   (input valid, text_attribute, output ready);
endinterface

// ===== design/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tcw_cursor.sv =====
// Put-character cursor step: control bytes, printable advance, wrap and scroll detect.
`timescale 1ns / 1ps

module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic [$clog2(COLUMNS)-1:0]      col,
  input  logic [$clog2(ROWS)-1:0]         row,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
  output logic [$clog2(COLUMNS)-1:0]      col_nxt,
  output logic [$clog2(ROWS)-1:0]         row_nxt,
  output tcw_pkg::put_flags_t             flags
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  logic [CW:0] col_t;
  logic [RW:0] row_t;

  always_comb begin
    col_t = {1'b0, col};
    row_t = {1'b0, row};
    flags = '0;
    unique case (char_code)
      tcw_pkg::CHAR_BS: begin
        if (col != '0) col_t = col_t - (CW+1)'(1);
      end
      tcw_pkg::CHAR_TAB: begin
        col_t = (col_t + (CW+1)'(8)) & ~(CW+1)'(7);
      end
      tcw_pkg::CHAR_CR: begin
        col_t = '0;
      end
      tcw_pkg::CHAR_LF: begin
        col_t = '0;
        row_t = row_t + (RW+1)'(1);
      end
      default: begin
        if (char_code >= tcw_pkg::CHAR_SPACE && char_code <= tcw_pkg::CHAR_LAST) begin
          flags.cell_wr = 1'b1;
          col_t         = col_t + (CW+1)'(1);
        end
      end
    endcase
    // right edge wrap
    if (col_t >= (CW+1)'(COLUMNS)) begin
      col_t = '0;
      row_t = row_t + (RW+1)'(1);
    end
    // bottom edge: caller sweeps the store up one row
    if (row_t >= (RW+1)'(ROWS)) begin
      flags.scroll = 1'b1;
      row_t        = (RW+1)'(ROWS - 1);
    end
  end

  assign col_nxt = col_t[CW-1:0];
  assign row_nxt = row_t[RW-1:0];

endmodule

// ===== design/text_console_char_writer_unit.sv =====
// Top level: text console character writer with cell store and sweep sequencer.
//
// Channels: in_ch takes one item (mode, char_code, cell_index); out_ch returns one
// result per item (column_now, row_now, read_data, scrolled); cfg_ch writes the
// text attribute byte and is always ready. Attribute writes are to be made while idle
// by the user; the block does not enforce it. Mode 0 puts a character, mode 1 blanks
// the store and homes the cursor, mode 2 reads one cell (zero beyond the store), mode 3
// only reports the cursor. Steps from input transfer to result: S_EXEC, then S_DONE,
// which loads the output register; a read inside the store passes S_READ between them.
// A put that scrolls adds a copy sweep that moves the rows up by one and a blanking
// pass over the last row; a clear adds a blanking pass over the whole store.
// The sweeps are bound by the single write port of the cell RAM, one cell per cycle.
// One item is in work at a time; in_ch.ready is high only while the sequencer is
// idle, so a new item is taken only after the last one has left its final step.
// The result sits in an output register, so a new item is taken while a result
// waits; a stalled receiver holds the block in its final step for the next item.
// Reset (rst_n low, synchronous) homes the cursor and sets the attribute to 0x0F;
// the cell store is not cleared and holds undefined data until written.
`timescale 1ns / 1ps

module text_console_char_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_ch,
  tcw_out_if.source  out_ch,
  tcw_cfg_if.sink    cfg_ch
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int SHIFT_N = (ROWS - 1) * COLUMNS;
  localparam int AW      = $clog2(CELLS);
  localparam int CW      = $clog2(COLUMNS);
  localparam int RW      = $clog2(ROWS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_BLANK = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [tcw_pkg::MODE_W-1:0]      mode_r, mode_nxt;
  logic [tcw_pkg::CHAR_W-1:0]      char_r, char_nxt;
  logic [tcw_pkg::INDEX_W-1:0]     index_r, index_nxt;
  logic [CW-1:0]                   col_r, col_nxt;
  logic [RW-1:0]                   row_r, row_nxt;
  logic [AW-1:0]                   ptr_r, ptr_nxt;
  logic                            scr_r, scr_nxt;
  logic [tcw_pkg::CELL_W-1:0]      rd_r, rd_nxt;
  logic [tcw_pkg::ATTR_W-1:0]      attr_r, attr_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [tcw_pkg::COLOUT_W-1:0]    out_col_r, out_col_nxt;
  logic [tcw_pkg::ROWOUT_W-1:0]    out_row_r, out_row_nxt;
  logic [tcw_pkg::CELL_W-1:0]      out_rd_r, out_rd_nxt;
  logic                            out_scr_r, out_scr_nxt;

  logic [CW-1:0]                   put_col;
  logic [RW-1:0]                   put_row;
  tcw_pkg::put_flags_t             put_flags;

  logic                            ram_we, ram_re;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]      ram_wdata, ram_rdata;
  logic [AW-1:0]                   cursor_addr;
  logic [tcw_pkg::CELL_W-1:0]      blank_cell;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .col       (col_r),
    .row       (row_r),
    .char_code (char_r),
    .col_nxt   (put_col),
    .row_nxt   (put_row),
    .flags     (put_flags)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cursor_addr  = AW'(row_r * COLUMNS) + AW'(col_r);
  assign blank_cell   = {attr_r, tcw_pkg::CHAR_SPACE};
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.column_now = out_col_r;
  assign out_ch.row_now    = out_row_r;
  assign out_ch.read_data  = out_rd_r;
  assign out_ch.scrolled   = out_scr_r;

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = blank_cell;
    ram_re    = 1'b0;
    ram_raddr = AW'(index_r);
    unique case (state_r)
      S_EXEC: begin
        if (mode_r == tcw_pkg::MODE_PUT && put_flags.cell_wr) begin
          ram_we    = 1'b1;
          ram_waddr = cursor_addr;
          ram_wdata = {attr_r, char_r};
        end
        if (mode_r == tcw_pkg::MODE_READ && 32'(index_r) < CELLS) begin
          ram_re = 1'b1;
        end
      end
      S_SHIFT: begin
        // read one row ahead, write the previous read one slot behind
        ram_re    = (ptr_r != AW'(SHIFT_N));
        ram_raddr = AW'(ptr_r + COLUMNS);
        ram_we    = (ptr_r != '0);
        ram_waddr = ptr_r - AW'(1);
        ram_wdata = ram_rdata;
      end
      S_BLANK, S_CLEAR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    char_nxt      = char_r;
    index_nxt     = index_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    ptr_nxt       = ptr_r;
    scr_nxt       = scr_r;
    rd_nxt        = rd_r;
    attr_nxt      = attr_r;
    out_valid_nxt = out_valid_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_rd_nxt    = out_rd_r;
    out_scr_nxt   = out_scr_r;

    if (cfg_ch.valid) attr_nxt = cfg_ch.text_attribute;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = in_ch.mode;
          char_nxt  = in_ch.char_code;
          index_nxt = in_ch.cell_index;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        rd_nxt  = '0;
        scr_nxt = 1'b0;
        ptr_nxt = '0;
        state_nxt = S_DONE;
        unique case (mode_r)
          tcw_pkg::MODE_PUT: begin
            col_nxt = put_col;
            row_nxt = put_row;
            scr_nxt = put_flags.scroll;
            if (put_flags.scroll) state_nxt = S_SHIFT;
          end
          tcw_pkg::MODE_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            state_nxt = S_CLEAR;
          end
          tcw_pkg::MODE_READ: begin
            if (32'(index_r) < CELLS) state_nxt = S_READ;
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_DONE;
      end
      S_SHIFT: begin
        // the last row start is where the blanking pass begins
        if (ptr_r == AW'(SHIFT_N)) state_nxt = S_BLANK;
        else ptr_nxt = ptr_r + AW'(1);
      end
      S_BLANK, S_CLEAR: begin
        if (ptr_r == AW'(CELLS - 1)) state_nxt = S_DONE;
        else ptr_nxt = ptr_r + AW'(1);
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = tcw_pkg::COLOUT_W'(col_r);
          out_row_nxt   = tcw_pkg::ROWOUT_W'(row_r);
          out_rd_nxt    = rd_r;
          out_scr_nxt   = scr_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= tcw_pkg::ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    char_r    <= char_nxt;
    index_r   <= index_nxt;
    ptr_r     <= ptr_nxt;
    scr_r     <= scr_nxt;
    rd_r      <= rd_nxt;
    out_col_r <= out_col_nxt;
    out_row_r <= out_row_nxt;
    out_rd_r  <= out_rd_nxt;
    out_scr_r <= out_scr_nxt;
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < COLUMNS && 32'(row_r) < ROWS)
    else $error("cursor outside the screen");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !ram_we)
    else $error("cell store written while idle");

  a_blank_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BLANK |-> row_r == RW'(ROWS - 1) && scr_r)
    else $error("blanking pass without scroll on last row");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside final step");

endmodule

// ===== dv/tb_text_console_char_writer_unit.sv =====
// Testbench for the text console character writer: self-predicting scoreboard, random traffic.
`timescale 1ns / 1ps

module tb_text_console_char_writer_unit;

  localparam int COLUMNS      = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS         = tcw_pkg::ROWS_DEF;
  localparam int CELL_COUNT   = COLUMNS * ROWS;
  localparam int TAB_STEP     = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_WAIT  = 8;
  localparam int TAIL_CYCLES  = 50;
  localparam int CYCLE_LIMIT  = 8000000;

  localparam logic [tcw_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Receiver stall styles, rotated in turn by the cycle count.
  localparam int STALL_NONE   = 0;
  localparam int STALL_PERIOD = 1;
  localparam int STALL_LIGHT  = 2;
  localparam int STALL_HEAVY  = 3;

  // Tracks cursor, cell store and attribute; holds the reports still owed by the block.
  class console_scoreboard;
    typedef struct {
      logic [tcw_pkg::COLOUT_W-1:0] column_now;
      logic [tcw_pkg::ROWOUT_W-1:0] row_now;
      logic [tcw_pkg::CELL_W-1:0]   read_data;
      logic                         scrolled;
    } report_t;

    logic [tcw_pkg::CELL_W-1:0] cells [CELL_COUNT];
    int unsigned                cur_col;
    int unsigned                cur_row;
    logic [tcw_pkg::ATTR_W-1:0] attr;
    report_t                    report_q [$];
    int unsigned                mismatches;
    int unsigned                checked;
    int unsigned                scrolls;
    int unsigned                clears;
    int unsigned                reads;
    int unsigned                wraps;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cur_col    = 0;
      cur_row    = 0;
      attr       = tcw_pkg::ATTR_RESET;
      mismatches = 0;
      checked    = 0;
      scrolls    = 0;
      clears     = 0;
      reads      = 0;
      wraps      = 0;
    endfunction

    function void set_attribute(logic [tcw_pkg::ATTR_W-1:0] value);
      attr = value;
    endfunction

    function logic [tcw_pkg::CELL_W-1:0] blank_cell();
      return {attr, tcw_pkg::CHAR_SPACE};
    endfunction

    function void note_item(logic [tcw_pkg::MODE_W-1:0] mode,
                            logic [tcw_pkg::CHAR_W-1:0] code,
                            logic [tcw_pkg::INDEX_W-1:0] idx);
      report_t r;
      r.read_data = '0;
      r.scrolled  = 1'b0;
      if (mode == tcw_pkg::MODE_PUT) begin
        if (code == tcw_pkg::CHAR_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (code == tcw_pkg::CHAR_TAB) begin
          cur_col = (cur_col / TAB_STEP + 1) * TAB_STEP;
        end else if (code == tcw_pkg::CHAR_CR) begin
          cur_col = 0;
        end else if (code == tcw_pkg::CHAR_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (code >= tcw_pkg::CHAR_SPACE && code <= tcw_pkg::CHAR_LAST) begin
          cells[cur_row * COLUMNS + cur_col] = {attr, code};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
          wraps++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
          for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) cells[i] = blank_cell();
          cur_row    = ROWS - 1;
          r.scrolled = 1'b1;
          scrolls++;
        end
      end else if (mode == tcw_pkg::MODE_CLEAR) begin
        foreach (cells[i]) cells[i] = blank_cell();
        cur_col = 0;
        cur_row = 0;
        clears++;
      end else if (mode == tcw_pkg::MODE_READ) begin
        if (idx < CELL_COUNT) r.read_data = cells[idx];
        reads++;
      end
      r.column_now = tcw_pkg::COLOUT_W'(cur_col);
      r.row_now    = tcw_pkg::ROWOUT_W'(cur_row);
      report_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(logic [tcw_pkg::COLOUT_W-1:0] column_now,
                               logic [tcw_pkg::ROWOUT_W-1:0] row_now,
                               logic [tcw_pkg::CELL_W-1:0] read_data, logic scrolled);
      report_t r;
      if (report_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual col %0d row %0d data 0x%0h",
                 $time, column_now, row_now, read_data);
        mismatches++;
        return;
      end
      r = report_q.pop_front();
      checked++;
      compare_field("column_now", r.column_now, column_now);
      compare_field("row_now", r.row_now, row_now);
      compare_field("read_data", r.read_data, read_data);
      compare_field("scrolled", r.scrolled, scrolled);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();
  tcw_cfg_if cfg_ch ();

  console_scoreboard board;
  int unsigned       cycle_count = 0;
  int unsigned       hold_asks = 0;
  int unsigned       hold_seen = 0;
  int unsigned       hold_left = 0;
  int unsigned       holdoffs = 0;
  int unsigned       items_sent = 0;
  int unsigned       burst_left = 0;
  int unsigned       attr_writes = 0;

  text_console_char_writer_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Valid stays high after a transfer; only idle gaps lower it.
  task automatic push_item(logic [tcw_pkg::MODE_W-1:0] mode, logic [tcw_pkg::CHAR_W-1:0] code,
                           logic [tcw_pkg::INDEX_W-1:0] idx);
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.char_code  <= code;
    in_ch.cell_index <= idx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_item(mode, code, idx);
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (board.report_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(logic [tcw_pkg::ATTR_W-1:0] value);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.text_attribute <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    board.set_attribute(value);
    attr_writes++;
  endtask

  function automatic logic [tcw_pkg::CHAR_W-1:0] pick_text_char();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 72)
      return tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CHAR_SPACE, tcw_pkg::CHAR_LAST));
    else if (w < 82) return tcw_pkg::CHAR_LF;
    else if (w < 86) return tcw_pkg::CHAR_CR;
    else if (w < 90) return tcw_pkg::CHAR_BS;
    else if (w < 94) return tcw_pkg::CHAR_TAB;
    else if (w < 97) return tcw_pkg::CHAR_W'($urandom_range(0, 31));
    else             return tcw_pkg::CHAR_W'($urandom_range(128, 255));
  endfunction

  // Just behind the cursor or anywhere, equally often; else any index, sometimes past the store.
  function automatic logic [tcw_pkg::INDEX_W-1:0] pick_read_index();
    int unsigned w;
    int unsigned at;
    w  = $urandom_range(0, 9);
    at = board.cur_row * COLUMNS + board.cur_col;
    if (w < 4)      return tcw_pkg::INDEX_W'(at == 0 ? 0 : at - 1);
    else if (w < 8) return tcw_pkg::INDEX_W'($urandom_range(0, CELL_COUNT - 1));
    else            return tcw_pkg::INDEX_W'($urandom_range(0, (1 << tcw_pkg::INDEX_W) - 1));
  endfunction

  task automatic random_items(int unsigned count);
    int unsigned gap;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      pick = $urandom_range(0, 999);
      if (pick < 780)
        push_item(tcw_pkg::MODE_PUT, pick_text_char(), tcw_pkg::INDEX_W'($urandom));
      else if (pick < 900)
        push_item(tcw_pkg::MODE_READ, tcw_pkg::CHAR_W'($urandom), pick_read_index());
      else if (pick < 903)
        push_item(tcw_pkg::MODE_CLEAR, tcw_pkg::CHAR_W'($urandom),
                  tcw_pkg::INDEX_W'($urandom));
      else if (pick < 940)
        push_item(MODE_UNUSED, tcw_pkg::CHAR_W'($urandom), tcw_pkg::INDEX_W'($urandom));
      else
        push_item(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_W'($urandom),
                  tcw_pkg::INDEX_W'($urandom));
    end
  endtask

  // Receiver: rotating stall styles plus one long hold-off.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
        holdoffs++;
        out_ch.ready <= 1'b0;
      end else begin
        case ((cycle_count >> 8) % 4)
          STALL_NONE:   out_ch.ready <= 1'b1;
          STALL_PERIOD: out_ch.ready <= (cycle_count % 3) != 0;
          STALL_LIGHT:  out_ch.ready <= $urandom_range(0, 3) != 0;
          default:      out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        board.check_report(out_ch.column_now, out_ch.row_now, out_ch.read_data,
                           out_ch.scrolled);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, board.report_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    board = new();
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.mode            <= tcw_pkg::MODE_PUT;
    in_ch.char_code       <= '0;
    in_ch.cell_index      <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.text_attribute <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: clear first so no cell is read before it is written.
    push_item(tcw_pkg::MODE_CLEAR, '0, '0);
    push_item(tcw_pkg::MODE_READ, '0, '0);
    push_item(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(CELL_COUNT - 1));
    push_item(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(CELL_COUNT));
    push_item(tcw_pkg::MODE_READ, 8'hFF, '1);
    push_item(MODE_UNUSED, 8'hFF, '1);
    push_item(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_SPACE, '0);
    push_item(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_LAST, '1);
    // high bytes and stray control bytes leave everything alone
    push_item(tcw_pkg::MODE_PUT, 8'h80, '0);
    push_item(tcw_pkg::MODE_PUT, 8'hFF, '0);
    push_item(tcw_pkg::MODE_PUT, 8'h00, '0);
    push_item(tcw_pkg::MODE_PUT, 8'h1F, '0);
    push_item(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, '0);
    push_item(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_CR, '0);
    push_item(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, '0);
    push_item(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(1));
    // tabs run off the right edge into the next row
    repeat (COLUMNS / TAB_STEP) push_item(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_TAB, '0);
    push_item(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_LF, '0);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      repeat (SETTLE_WAIT) @(posedge clk);
      if (p == 0)      write_attribute(8'h00);
      else if (p == 1) write_attribute(8'hFF);
      else             write_attribute(tcw_pkg::ATTR_W'($urandom));
      if (p == 2) hold_asks++;
      random_items(PHASE_ITEMS);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.report_q.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, board.report_q.size());
      board.mismatches++;
    end

    $display("%0d items sent, %0d results checked, %0d mismatches, %0d cycles",
             items_sent, board.checked, board.mismatches, cycle_count);
    $display("covered %0d scrolls, %0d wraps, %0d clears, %0d reads,",
             board.scrolls, board.wraps, board.clears, board.reads);
    $display("  %0d attribute writes, %0d hold-offs", attr_writes, holdoffs);
    if (board.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
